### design/bast_pkg.sv
// ----------------------------------------------------------------------------
// bast_pkg
// Shared types, codes and helpers for the bit array core: request codes,
// register map, control bundles and the word population count.
// ----------------------------------------------------------------------------
package bast_pkg;

	// Default sizing of the store
	localparam int MAX_BITS_DEF  = 4096;
	localparam int WORD_BITS_DEF = 32;

	// Request codes carried on the mode field
	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TEST      = 3'd2;
	localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd4;

	// Register map of the configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] ADDR_SIZE = 3'd0;

	// Byte mask used by the population count
	localparam logic [7:0] BYTE_MASK = 8'hff;

	// Widest word the count helper takes
	localparam int POP_IN_W  = 64;
	localparam int POP_OUT_W = 7;

	// Ones in each nibble value
	localparam logic [2:0] NIBBLE_ONES [16] = '{
		3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
		3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
	};

	// Store control bundle from the sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr_all;
	} st_ctrl_t;

	// Word unit control bundle from the sequencer
	typedef struct packed {
		logic op_set;
		logic op_clr;
		logic acc_clr;
		logic acc_en;
	} wu_ctrl_t;

	// Count the ones of a word, one byte at a time through the nibble table
	function automatic logic [POP_OUT_W-1:0] pop_count(input logic [POP_IN_W-1:0] w);
		logic [POP_OUT_W-1:0] total;
		logic [7:0]           byte_v;
		total = '0;
		for (int i = 0; i < POP_IN_W / 8; i++) begin
			byte_v = w[8*i +: 8] & BYTE_MASK;
			total  = total + POP_OUT_W'(NIBBLE_ONES[byte_v[3:0]])
				+ POP_OUT_W'(NIBBLE_ONES[byte_v[7:4]]);
		end
		return total;
	endfunction

endpackage

### design/bast_store.sv
// ----------------------------------------------------------------------------
// bast_store
// Word store of the bit array: one write port, one read port with a
// registered read, and a valid bit per word so that reset and clear-all
// take effect at once. A word never written since then reads as zero.
// ----------------------------------------------------------------------------
module bast_store #(
	parameter int DEPTH     = 128,
	parameter int AW        = 7,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bast_pkg::st_ctrl_t   ctrl,
	input  logic [AW-1:0]        rd_addr,
	input  logic [AW-1:0]        wr_addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_vld_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// Track which words hold written data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.clr_all) begin
				vld_q <= '0;
			end else if (ctrl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// Drop data of words that are not valid
	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

### design/bast_word_unit.sv
// ----------------------------------------------------------------------------
// bast_word_unit
// Shared word unit: picks out one bit, sets or clears it for the write
// back, and adds the word's population count into the running total.
// ----------------------------------------------------------------------------
module bast_word_unit #(
	parameter int WORD_BITS = 32,
	parameter int OW        = 5,
	parameter int CAPW      = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bast_pkg::wu_ctrl_t   ctrl,
	input  logic [WORD_BITS-1:0] word,
	input  logic [OW-1:0]        off,
	output logic [WORD_BITS-1:0] new_word,
	output logic                 bit_val,
	output logic [CAPW-1:0]      acc
);

	logic [WORD_BITS-1:0]               mask;
	logic [bast_pkg::POP_OUT_W-1:0]     ones;
	logic [CAPW-1:0]                    acc_q;

	// Select the addressed bit and build the modified word
	always_comb begin
		mask    = WORD_BITS'(1) << off;
		bit_val = |(word & mask);
		if (ctrl.op_set) begin
			new_word = word | mask;
		end else if (ctrl.op_clr) begin
			new_word = word & ~mask;
		end else begin
			new_word = word;
		end
	end

	assign ones = bast_pkg::pop_count(bast_pkg::POP_IN_W'(word));

	// Accumulate set bits over the walked words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + CAPW'(ones);
		end
	end

	assign acc = acc_q;

endmodule

### design/bit_array_set_test_count_core.sv
// ----------------------------------------------------------------------------
// bit_array_set_test_count_core
// Bit array with set, clear, test, population count and clear-all requests.
// ----------------------------------------------------------------------------
// The core takes one request word at a time. in_stall stays high from the
// cycle after acceptance until the result is loaded into the output
// register. A waiting result does not block the next request, but that
// request holds in its last step until the output register is free.
// Set, clear and test step through word index, registered read, modify and
// write back, and result load. A position whose word lies outside the words
// in use skips the modify step. For count the word unit adds the population
// of one stored word per cycle over the read port, then loads the result;
// with no word in use count goes straight to the result load. Clear-all and
// unused modes also go straight to the result load; clear-all drops all
// word valid bits at once. The words in use are the size register rounded
// up to whole words, capped at the store depth.
// ----------------------------------------------------------------------------
module bit_array_set_test_count_core #(
	parameter int MAX_BITS  = bast_pkg::MAX_BITS_DEF,
	parameter int WORD_BITS = bast_pkg::WORD_BITS_DEF,
	localparam int PW       = $clog2(MAX_BITS),
	localparam int CW       = $clog2(MAX_BITS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [bast_pkg::MODE_W-1:0]     mode,
	input  logic [PW-1:0]                   bit_position,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            bit_value,
	output logic                            status,
	output logic [CW-1:0]                   set_count,
	output logic [CW-1:0]                   unset_count,
	// configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bast_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bast_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bast_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int DEPTH = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OW    = $clog2(WORD_BITS);
	localparam int UW    = $clog2(DEPTH + 1) + 1;
	localparam int CAPW  = $clog2(DEPTH * WORD_BITS + 1);
	// Division by the word size: multiply by a rounded-up reciprocal
	localparam int DW    = $clog2((2 ** CW) + WORD_BITS);
	localparam int SHD   = DW + OW;
	localparam int RW    = DW + 2;
	localparam int PRW   = DW + RW;
	localparam logic [63:0] RECIP = ((64'd1 << SHD) + 64'(WORD_BITS) - 64'd1)
		/ 64'(WORD_BITS);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INDEX    = 7'b0000010,
		S_READ     = 7'b0000100,
		S_MODIFY   = 7'b0001000,
		S_CNT      = 7'b0010000,
		S_CNT_TAIL = 7'b0100000,
		S_DONE     = 7'b1000000
	} state_t;

	state_t                      state_q, state_d;
	logic [bast_pkg::MODE_W-1:0] mode_q;
	logic [PW-1:0]               pos_q;
	logic [UW-1:0]               widx_q;
	logic [OW-1:0]               off_q;
	logic [UW-1:0]               cnt_q;
	logic [UW-1:0]               used_q;
	logic [CW-1:0]               size_q;
	logic [CAPW-1:0]             cap_q;
	logic                        res_bit_q;
	logic                        res_status_q;
	logic                        is_count_q;
	logic                        out_valid_q;
	logic                        bit_value_q;
	logic                        status_q;
	logic [CW-1:0]               set_count_q;
	logic [CW-1:0]               unset_count_q;

	logic                        in_acc;
	logic                        out_free;
	logic                        cfg_wr;
	logic                        in_range;
	logic [DW-1:0]               size_plus;
	logic [PRW-1:0]              used_prod;
	logic [PRW-1:0]              used_raw;
	logic [PRW-1:0]              pos_prod;
	logic [PW-1:0]               wbase;
	logic [CAPW-1:0]             unset_full;

	bast_pkg::st_ctrl_t          st_ctrl;
	bast_pkg::wu_ctrl_t          wu_ctrl;
	logic [AW-1:0]               rd_addr;
	logic [WORD_BITS-1:0]        rd_word;
	logic [WORD_BITS-1:0]        new_word;
	logic                        wu_bit;
	logic [CAPW-1:0]             acc;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_range = (widx_q < used_q);

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == bast_pkg::ADDR_SIZE);
	assign prdata = (paddr == bast_pkg::ADDR_SIZE) ? bast_pkg::APB_DATA_W'(size_q) : '0;

	// Words in use for a newly written size
	assign size_plus = DW'(pwdata[CW-1:0]) + DW'(WORD_BITS - 1);
	assign used_prod = PRW'(size_plus) * PRW'(RECIP[RW-1:0]);
	assign used_raw  = used_prod >> SHD;

	// Word index of the requested bit
	assign pos_prod = PRW'(pos_q) * PRW'(RECIP[RW-1:0]);
	assign wbase    = PW'(32'(widx_q) * 32'(WORD_BITS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CW'(MAX_BITS);
			used_q <= UW'(DEPTH);
		end else if (cfg_wr) begin
			size_q <= pwdata[CW-1:0];
			used_q <= (used_raw > PRW'(DEPTH)) ? UW'(DEPTH) : UW'(used_raw);
		end
	end

	// Sequence the store and the word unit
	always_comb begin
		state_d         = state_q;
		st_ctrl         = '0;
		wu_ctrl         = '0;
		wu_ctrl.op_set  = (mode_q == bast_pkg::MODE_SET);
		wu_ctrl.op_clr  = (mode_q == bast_pkg::MODE_CLEAR);
		rd_addr         = widx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					wu_ctrl.acc_clr = 1'b1;
					unique case (mode) inside
						bast_pkg::MODE_SET, bast_pkg::MODE_CLEAR,
						bast_pkg::MODE_TEST: begin
							state_d = S_INDEX;
						end
						bast_pkg::MODE_COUNT: begin
							state_d = (used_q != '0) ? S_CNT : S_DONE;
						end
						bast_pkg::MODE_CLEAR_ALL: begin
							st_ctrl.clr_all = 1'b1;
							state_d         = S_DONE;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_INDEX: begin
				state_d = S_READ;
			end
			S_READ: begin
				st_ctrl.rd_en = in_range;
				state_d       = in_range ? S_MODIFY : S_DONE;
			end
			S_MODIFY: begin
				st_ctrl.wr_en = (mode_q == bast_pkg::MODE_SET)
					|| (mode_q == bast_pkg::MODE_CLEAR);
				state_d       = S_DONE;
			end
			S_CNT: begin
				rd_addr        = cnt_q[AW-1:0];
				st_ctrl.rd_en  = 1'b1;
				wu_ctrl.acc_en = (cnt_q != '0);
				if (cnt_q == used_q - UW'(1)) begin
					state_d = S_CNT_TAIL;
				end
			end
			S_CNT_TAIL: begin
				wu_ctrl.acc_en = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold request and working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					mode_q       <= mode;
					pos_q        <= bit_position;
					cnt_q        <= '0;
					res_bit_q    <= 1'b0;
					res_status_q <= 1'b0;
					is_count_q   <= (mode == bast_pkg::MODE_COUNT);
					cap_q        <= CAPW'(32'(used_q) * 32'(WORD_BITS));
				end
			end
			S_INDEX: begin
				widx_q <= UW'(pos_prod >> SHD);
			end
			S_READ: begin
				off_q        <= OW'(pos_q - wbase);
				res_status_q <= !in_range;
			end
			S_MODIFY: begin
				res_bit_q <= wu_bit && ((mode_q == bast_pkg::MODE_CLEAR)
					|| (mode_q == bast_pkg::MODE_TEST));
			end
			S_CNT: begin
				cnt_q <= cnt_q + UW'(1);
			end
			default: begin
			end
		endcase
	end

	assign unset_full = cap_q - acc;

	// Load the result word and drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			bit_value_q   <= res_bit_q;
			status_q      <= res_status_q;
			set_count_q   <= is_count_q ? CW'(acc) : '0;
			unset_count_q <= is_count_q ? CW'(unset_full) : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign bit_value   = bit_value_q;
	assign status      = status_q;
	assign set_count   = set_count_q;
	assign unset_count = unset_count_q;

	bast_store #(
		.DEPTH     (DEPTH),
		.AW        (AW),
		.WORD_BITS (WORD_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (st_ctrl),
		.rd_addr (rd_addr),
		.wr_addr (widx_q[AW-1:0]),
		.wr_data (new_word),
		.rd_data (rd_word)
	);

	bast_word_unit #(
		.WORD_BITS (WORD_BITS),
		.OW        (OW),
		.CAPW      (CAPW)
	) u_word_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (wu_ctrl),
		.word     (rd_word),
		.off      (off_q),
		.new_word (new_word),
		.bit_val  (wu_bit),
		.acc      (acc)
	);

endmodule

### design/bast_checker.sv
// ----------------------------------------------------------------------------
// bast_checker
// Port-level checks of the bit array core, bound to its top level.
// ----------------------------------------------------------------------------
module bast_checker #(
	parameter int CW = 13
) (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input logic          bit_value,
	input logic          status,
	input logic [CW-1:0] set_count,
	input logic [CW-1:0] unset_count
);

	// One request at a time: busy right after a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while a request is in progress");

	// A new result only appears at the end of a request's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in progress");

	// An out-of-range result carries no bit and no counts
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> !bit_value && (set_count == '0) && (unset_count == '0))
		else $error("out-of-range result carries data");

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bit_value) && $stable(status)
			&& $stable(set_count) && $stable(unset_count))
		else $error("stalled result word changed");

endmodule

bind bit_array_set_test_count_core bast_checker #(
	.CW (CW)
) u_bast_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.bit_value   (bit_value),
	.status      (status),
	.set_count   (set_count),
	.unset_count (unset_count)
);
